@@ hw/rtl/mlsf_pkg.sv @@
`timescale 1ns / 1ps
// Types, codes and byte-lane helpers shared by the misaligned load/store fixup unit.
package mlsf_pkg;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_OK    = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic [2:0] DK_NONE = 3'd0;
	localparam logic [2:0] DK_INT  = 3'd1;
	localparam logic [2:0] DK_FSGL = 3'd2;
	localparam logic [2:0] DK_FDBL = 3'd3;
	localparam logic [2:0] DK_FSR  = 3'd4;

	localparam logic [4:0] SZ_NONE = 5'd0;
	localparam logic [4:0] SZ_BYTE = 5'd1;
	localparam logic [4:0] SZ_HALF = 5'd2;
	localparam logic [4:0] SZ_WORD = 5'd4;
	localparam logic [4:0] SZ_DBL  = 5'd8;
	localparam logic [4:0] SZ_QUAD = 5'd16;

	localparam logic [7:0] ASI_P    = 8'h80;
	localparam logic [7:0] ASI_S    = 8'h81;
	localparam logic [7:0] ASI_PL   = 8'h88;
	localparam logic [7:0] ASI_SL   = 8'h89;

	localparam logic [1:0] OP_MEM = 2'b11;
	localparam logic [5:0] OP3_SWAP_MASK = 6'h0d;
	localparam logic [5:0] OP3_RSVD_MASK = 6'h0f;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic [31:0] LIMIT_RESET = 32'hffff_ffff;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [4:0]  access_size;
		logic        is_store;
		logic [63:0] mem_write_low;
		logic [63:0] mem_write_high;
		logic [2:0]  dest_kind;
		logic [4:0]  dest_index;
		logic [63:0] write_first;
		logic [63:0] write_second;
		logic        pair_write;
	} result_t;

	function automatic logic [63:0] size_mask(input logic [4:0] sz);
		case (sz)
			SZ_BYTE: size_mask = 64'h0000_0000_0000_00ff;
			SZ_HALF: size_mask = 64'h0000_0000_0000_ffff;
			SZ_WORD: size_mask = 64'h0000_0000_ffff_ffff;
			default: size_mask = '1;
		endcase
	endfunction

	function automatic logic [63:0] rev64(input logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		rev64 = r;
	endfunction

	function automatic logic [63:0] rev_sized(input logic [63:0] v, input logic [4:0] sz);
		case (sz)
			SZ_HALF: rev_sized = {48'd0, v[7:0], v[15:8]};
			SZ_WORD: rev_sized = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
			SZ_DBL:  rev_sized = rev64(v);
			SZ_QUAD: rev_sized = rev64(v);
			default: rev_sized = {56'd0, v[7:0]};
		endcase
	endfunction

endpackage

@@ hw/rtl/misaligned_load_store_fixup_unit.sv @@
`timescale 1ns / 1ps
// Misaligned load/store fixup unit: decode, address check and byte formatting.
//
// channel | handshake                   | words
// in      | in_valid / in_ready         | instruction, operands, asi, store and fetched data
// out     | out_valid / out_ready       | status, address, size, store image, load writes
// cfg     | psel penable pwrite pready  | user_address_limit at byte address 0
//
// Path from acceptance to result: input register, one pass of decode,
// 32-bit address add and limit compare, then the result register.
// One word per cycle sustained; in_ready drops only when both registers are full
// and out_ready is low.
// Reset clears the valid flags and sets the limit to all ones.
module misaligned_load_store_fixup_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	input  logic [63:0] base_value,
	input  logic [63:0] index_value,
	input  logic [7:0]  default_asi,
	input  logic [63:0] store_first,
	input  logic [63:0] store_second,
	input  logic [63:0] memory_low,
	input  logic [63:0] memory_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] address,
	output logic [4:0]  access_size,
	output logic        is_store,
	output logic [63:0] mem_write_low,
	output logic [63:0] mem_write_high,
	output logic [2:0]  dest_kind,
	output logic [4:0]  dest_index,
	output logic [63:0] write_first,
	output logic [63:0] write_second,
	output logic        pair_write,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mlsf_pkg::*;

	logic        v_s1;
	logic        v_s2;
	logic [31:0] limit_q;
	logic [31:0] inst_s1;
	logic [31:0] base_s1;
	logic [31:0] index_s1;
	logic [7:0]  dasi_s1;
	logic [63:0] sf_s1;
	logic [63:0] ss_s1;
	logic [63:0] ml_s1;
	logic [63:0] mh_s1;
	result_t     res;
	result_t     res_s2;
	logic        in_fire;
	logic        adv;

	assign in_fire = in_valid && in_ready;
	assign adv = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || !v_s2 || out_ready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			inst_s1  <= instruction;
			base_s1  <= base_value[31:0];
			index_s1 <= index_value[31:0];
			dasi_s1  <= default_asi;
			sf_s1    <= store_first;
			ss_s1    <= store_second;
			ml_s1    <= memory_low;
			mh_s1    <= memory_high;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		logic [5:0]  op3;
		logic [4:0]  rd;
		logic [4:0]  rd_eff;
		logic        is_flt;
		logic        imm;
		logic        st;
		logic        sgn;
		logic        fsr;
		logic        pair;
		logic [4:0]  sz;
		logic [7:0]  asi;
		logic        little;
		logic        asi_bad;
		logic        handled;
		logic [31:0] addr;
		logic [63:0] mask;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] first;
		logic [63:0] second;
		logic        top;

		op3    = inst_s1[24:19];
		rd     = inst_s1[29:25];
		is_flt = inst_s1[24];
		imm    = inst_s1[13];
		st     = inst_s1[21];
		sgn    = inst_s1[22];
		fsr    = 1'b0;
		pair   = 1'b0;
		sz     = SZ_NONE;
		rd_eff = rd;

		if (is_flt) begin
			case (op3[1:0])
				2'd0: sz = SZ_WORD;
				2'd1: begin
					fsr = 1'b1;
					sz = (rd == 5'd0) ? SZ_WORD : SZ_DBL;
				end
				2'd2: sz = SZ_QUAD;
				default: sz = SZ_DBL;
			endcase
			if (sz != SZ_WORD && !fsr) begin
				rd_eff = {rd[0], rd[4:1]};
			end
		end else begin
			case (op3[3:0])
				4'h0, 4'h4, 4'h8: sz = SZ_WORD;
				4'h1, 4'h5, 4'h9: sz = SZ_BYTE;
				4'h2, 4'h6, 4'ha: sz = SZ_HALF;
				4'h3, 4'h7: begin
					pair = 1'b1;
					sz = SZ_DBL;
				end
				4'hb, 4'he: sz = SZ_DBL;
				default: sz = SZ_NONE;
			endcase
		end

		asi = imm ? dasi_s1 : inst_s1[12:5];
		little = op3[4] && (asi == ASI_PL || asi == ASI_SL);
		asi_bad = op3[4] && !(asi == ASI_PL || asi == ASI_SL || asi == ASI_P || asi == ASI_S);
		handled = (inst_s1[31:30] == OP_MEM) && ((op3 & OP3_SWAP_MASK) != OP3_SWAP_MASK)
			&& ((op3 & OP3_RSVD_MASK) != OP3_RSVD_MASK) && (sz != SZ_NONE) && !asi_bad;

		addr = base_s1 + (imm ? {{19{inst_s1[12]}}, inst_s1[12:0]} : index_s1);
		mask = size_mask(sz);

		lo = pair ? {sf_s1[31:0], ss_s1[31:0]} : (sf_s1 & mask);
		hi = (sz == SZ_QUAD) ? ss_s1 : 64'd0;
		if (little) begin
			if (sz == SZ_QUAD) begin
				lo = rev64(ss_s1);
				hi = rev64(sf_s1);
			end else begin
				lo = rev_sized(lo, sz);
			end
		end

		second = 64'd0;
		top = 1'b0;
		if (sz == SZ_QUAD) begin
			first = little ? rev64(mh_s1) : ml_s1;
			second = little ? rev64(ml_s1) : mh_s1;
		end else begin
			first = ml_s1 & mask;
			if (little) begin
				first = rev_sized(first, sz);
			end
			case (sz)
				SZ_BYTE: top = first[7];
				SZ_HALF: top = first[15];
				SZ_WORD: top = first[31];
				default: top = 1'b0;
			endcase
			if (sgn && top) begin
				first = first | ~mask;
			end
		end

		res = '0;
		if (handled) begin
			res.address = addr;
			res.access_size = sz;
			res.is_store = st;
			if (addr >= limit_q) begin
				res.status = ST_FAULT;
			end else begin
				res.status = ST_OK;
				if (st) begin
					res.mem_write_low = lo;
					res.mem_write_high = hi;
				end else if (is_flt) begin
					if (fsr) begin
						res.dest_kind = DK_FSR;
						res.write_first = first;
					end else if (sz == SZ_WORD) begin
						res.dest_kind = DK_FSGL;
						res.dest_index = rd_eff;
						res.write_first = {32'd0, first[31:0]};
					end else begin
						res.dest_kind = DK_FDBL;
						res.dest_index = rd_eff;
						res.write_first = first;
						if (sz == SZ_QUAD) begin
							res.write_second = second;
							res.pair_write = 1'b1;
						end
					end
				end else begin
					res.dest_kind = DK_INT;
					res.dest_index = rd_eff;
					if (pair) begin
						res.write_first = {32'd0, first[63:32]};
						res.write_second = {32'd0, first[31:0]};
						res.pair_write = 1'b1;
					end else begin
						res.write_first = first;
					end
				end
			end
		end
	end

	assign out_valid      = v_s2;
	assign status         = res_s2.status;
	assign address        = res_s2.address;
	assign access_size    = res_s2.access_size;
	assign is_store       = res_s2.is_store;
	assign mem_write_low  = res_s2.mem_write_low;
	assign mem_write_high = res_s2.mem_write_high;
	assign dest_kind      = res_s2.dest_kind;
	assign dest_index     = res_s2.dest_index;
	assign write_first    = res_s2.write_first;
	assign write_second   = res_s2.write_second;
	assign pair_write     = res_s2.pair_write;

`ifndef NO_ASSERTIONS
	a_fault_no_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FAULT |-> dest_kind == DK_NONE && !pair_write
			&& mem_write_low == 64'd0 && mem_write_high == 64'd0)
		else $error("fault result carries write data");

	a_store_no_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_store |-> dest_kind == DK_NONE && write_first == 64'd0)
		else $error("store result names a destination");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NONE |-> address == 32'd0 && access_size == SZ_NONE)
		else $error("unhandled result is not cleared");

	a_pair_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_write |-> (dest_kind == DK_INT && access_size == SZ_DBL)
			|| (dest_kind == DK_FDBL && access_size == SZ_QUAD))
		else $error("pair write on a single-register load");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !out_ready |=> v_s1 && v_s2)
		else $error("pipeline word lost under stall");
`endif

endmodule
